// File: src/via_pkg.sv
// shared types, register codes and mode codes of the interface adapter
package via_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // register select codes
    localparam logic [3:0] REG_ORB   = 4'h0;
    localparam logic [3:0] REG_ORA   = 4'h1;
    localparam logic [3:0] REG_DDRB  = 4'h2;
    localparam logic [3:0] REG_DDRA  = 4'h3;
    localparam logic [3:0] REG_T1CL  = 4'h4;
    localparam logic [3:0] REG_T1CH  = 4'h5;
    localparam logic [3:0] REG_T1LL  = 4'h6;
    localparam logic [3:0] REG_T1LH  = 4'h7;
    localparam logic [3:0] REG_T2CL  = 4'h8;
    localparam logic [3:0] REG_T2CH  = 4'h9;
    localparam logic [3:0] REG_SR    = 4'hA;
    localparam logic [3:0] REG_ACR   = 4'hB;
    localparam logic [3:0] REG_PCR   = 4'hC;
    localparam logic [3:0] REG_IFR   = 4'hD;
    localparam logic [3:0] REG_IER   = 4'hE;
    localparam logic [3:0] REG_ORA_NH = 4'hF;

    // interrupt flag bit positions
    localparam int unsigned FLG_SR = 2;
    localparam int unsigned FLG_T2 = 5;
    localparam int unsigned FLG_T1 = 6;

    // acr bit positions
    localparam int unsigned ACR_T2_PULSE = 5;
    localparam int unsigned ACR_T1_FREE  = 6;
    localparam int unsigned ACR_T1_PB7   = 7;

    // acr shift modes (bits 4:2)
    localparam logic [2:0] SR_IN_T2   = 3'b001;
    localparam logic [2:0] SR_IN_SYS  = 3'b010;
    localparam logic [2:0] SR_FREE_T2 = 3'b100;
    localparam logic [2:0] SR_OUT_T2  = 3'b101;
    localparam logic [2:0] SR_OUT_SYS = 3'b110;

    // pcr control line modes (ca2 in bits 3:1, cb2 in bits 7:5)
    localparam logic [2:0] C2_HANDSHAKE = 3'b100;
    localparam logic [2:0] C2_PULSE     = 3'b101;
    localparam logic [2:0] C2_LOW       = 3'b110;

    // port b bits 4:3 value that puts the external byte on port a reads
    localparam logic [1:0] PB_SEL_EXT = 2'b01;

    localparam logic [3:0] SR_BITS_IDLE = 4'd8;

    typedef struct packed {
        logic [7:0] port_a_external;
        logic       compare_in;
        logic [7:0] write_data;
        logic [3:0] reg_index;
        logic [1:0] action;
    } t_via_item;

    typedef struct packed {
        logic       cb2_shift;
        logic       cb2_handshake;
        logic       ca2_level;
        logic       pb7_timer;
        logic [7:0] port_b_out;
        logic [7:0] port_a_out;
        logic       irq;
        logic [7:0] read_data;
    } t_via_result;

endpackage

// File: src/via_core.sv
// register file, timers, shifter and interrupt logic updated once per word
module via_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  via_pkg::t_via_item   i_item,
    output via_pkg::t_via_result o_result
);

    logic [7:0]  r_out_a, n_out_a, r_out_b, n_out_b;
    logic [7:0]  r_dir_a, n_dir_a, r_dir_b, n_dir_b;
    logic        r_t1_running, n_t1_running, r_t1_armed, n_t1_armed;
    logic [15:0] r_t1_count, n_t1_count;
    logic [7:0]  r_t1_latch_lo, n_t1_latch_lo, r_t1_latch_hi, n_t1_latch_hi;
    logic        r_t1_pb7, n_t1_pb7;
    logic        r_t2_running, n_t2_running, r_t2_armed, n_t2_armed;
    logic [15:0] r_t2_count, n_t2_count;
    logic [7:0]  r_t2_latch_lo, n_t2_latch_lo;
    logic [7:0]  r_shift_reg, n_shift_reg;
    logic [3:0]  r_shift_done, n_shift_done;
    logic [7:0]  r_shift_div, n_shift_div;
    logic        r_shift_phase, n_shift_phase;
    logic [7:0]  r_acr, n_acr, r_pcr, n_pcr;
    logic [7:0]  r_ifr, n_ifr;
    logic [6:0]  r_ier, n_ier;
    logic        r_ca2, n_ca2, r_cb2_hand, n_cb2_hand, r_cb2_shift, n_cb2_shift;
    logic [7:0]  read_data;

    always_comb begin
        logic       t2_pace;
        logic [6:0] flags;
        n_out_a = r_out_a;             n_out_b = r_out_b;
        n_dir_a = r_dir_a;             n_dir_b = r_dir_b;
        n_t1_running = r_t1_running;   n_t1_armed = r_t1_armed;
        n_t1_count = r_t1_count;       n_t1_pb7 = r_t1_pb7;
        n_t1_latch_lo = r_t1_latch_lo; n_t1_latch_hi = r_t1_latch_hi;
        n_t2_running = r_t2_running;   n_t2_armed = r_t2_armed;
        n_t2_count = r_t2_count;       n_t2_latch_lo = r_t2_latch_lo;
        n_shift_reg = r_shift_reg;     n_shift_done = r_shift_done;
        n_shift_div = r_shift_div;     n_shift_phase = r_shift_phase;
        n_acr = r_acr;                 n_pcr = r_pcr;
        n_ier = r_ier;
        n_ca2 = r_ca2;                 n_cb2_hand = r_cb2_hand;
        n_cb2_shift = r_cb2_shift;
        flags = r_ifr[6:0];
        t2_pace = 1'b0;
        read_data = 8'h00;

        unique case (i_item.action)
            via_pkg::ACT_TICK: begin
                // timer 1
                if (r_t1_running) begin
                    n_t1_count = r_t1_count - 16'd1;
                    if (r_t1_count == 16'd0) begin
                        if (r_acr[via_pkg::ACR_T1_FREE]) begin
                            flags[via_pkg::FLG_T1] = 1'b1;
                            n_t1_pb7 = ~r_t1_pb7;
                            n_t1_count = {r_t1_latch_hi, r_t1_latch_lo};
                        end else if (r_t1_armed) begin
                            flags[via_pkg::FLG_T1] = 1'b1;
                            n_t1_pb7 = 1'b1;
                            n_t1_armed = 1'b0;
                        end
                    end
                end
                // timer 2, held while pulse counting is selected
                if (r_t2_running && !r_acr[via_pkg::ACR_T2_PULSE]) begin
                    n_t2_count = r_t2_count - 16'd1;
                    if (r_t2_count == 16'd0 && r_t2_armed) begin
                        flags[via_pkg::FLG_T2] = 1'b1;
                        n_t2_armed = 1'b0;
                    end
                end
                // shift clock divider
                n_shift_div = r_shift_div - 8'd1;
                if (r_shift_div == 8'd0) begin
                    n_shift_div = r_t2_latch_lo;
                    t2_pace = r_shift_phase;
                    n_shift_phase = ~r_shift_phase;
                end
                // shifter
                if (r_shift_done < via_pkg::SR_BITS_IDLE) begin
                    case (r_acr[4:2])
                        via_pkg::SR_IN_T2: begin
                            if (t2_pace) begin
                                n_shift_reg = {r_shift_reg[6:0], 1'b0};
                                n_shift_done = r_shift_done + 4'd1;
                            end
                        end
                        via_pkg::SR_IN_SYS: begin
                            n_shift_reg = {r_shift_reg[6:0], 1'b0};
                            n_shift_done = r_shift_done + 4'd1;
                        end
                        via_pkg::SR_FREE_T2: begin
                            if (t2_pace) begin
                                n_cb2_shift = r_shift_reg[7];
                                n_shift_reg = {r_shift_reg[6:0], r_shift_reg[7]};
                            end
                        end
                        via_pkg::SR_OUT_T2: begin
                            if (t2_pace) begin
                                n_cb2_shift = r_shift_reg[7];
                                n_shift_reg = {r_shift_reg[6:0], r_shift_reg[7]};
                                n_shift_done = r_shift_done + 4'd1;
                            end
                        end
                        via_pkg::SR_OUT_SYS: begin
                            n_cb2_shift = r_shift_reg[7];
                            n_shift_reg = {r_shift_reg[6:0], r_shift_reg[7]};
                            n_shift_done = r_shift_done + 4'd1;
                        end
                        default: ;
                    endcase
                    if (n_shift_done == via_pkg::SR_BITS_IDLE) begin
                        flags[via_pkg::FLG_SR] = 1'b1;
                    end
                end
                // pulse modes release the line on every tick
                if (r_pcr[3:1] == via_pkg::C2_PULSE) begin
                    n_ca2 = 1'b1;
                end
                if (r_pcr[7:5] == via_pkg::C2_PULSE) begin
                    n_cb2_hand = 1'b1;
                end
            end
            via_pkg::ACT_READ: begin
                unique case (i_item.reg_index) inside
                    via_pkg::REG_ORB: begin
                        if (r_acr[via_pkg::ACR_T1_PB7]) begin
                            read_data = {r_t1_pb7, r_out_b[6], i_item.compare_in,
                                         r_out_b[4:0]};
                        end else begin
                            read_data = {r_out_b[7:6], i_item.compare_in, r_out_b[4:0]};
                        end
                    end
                    via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
                        if (i_item.reg_index == via_pkg::REG_ORA &&
                            r_pcr[3:1] == via_pkg::C2_HANDSHAKE) begin
                            n_ca2 = 1'b0;
                        end
                        read_data = (r_out_b[4:3] == via_pkg::PB_SEL_EXT) ?
                                    i_item.port_a_external : r_out_a;
                    end
                    via_pkg::REG_DDRB: read_data = r_dir_b;
                    via_pkg::REG_DDRA: read_data = r_dir_a;
                    via_pkg::REG_T1CL: begin
                        read_data = r_t1_count[7:0];
                        flags[via_pkg::FLG_T1] = 1'b0;
                        n_t1_running = 1'b0;
                        n_t1_armed = 1'b0;
                        n_t1_pb7 = 1'b1;
                    end
                    via_pkg::REG_T1CH: read_data = r_t1_count[15:8];
                    via_pkg::REG_T1LL: read_data = r_t1_latch_lo;
                    via_pkg::REG_T1LH: read_data = r_t1_latch_hi;
                    via_pkg::REG_T2CL: begin
                        read_data = r_t2_count[7:0];
                        flags[via_pkg::FLG_T2] = 1'b0;
                        n_t2_running = 1'b0;
                        n_t2_armed = 1'b0;
                    end
                    via_pkg::REG_T2CH: read_data = r_t2_count[15:8];
                    via_pkg::REG_SR: begin
                        read_data = r_shift_reg;
                        flags[via_pkg::FLG_SR] = 1'b0;
                        n_shift_done = 4'd0;
                        n_shift_phase = 1'b1;
                    end
                    via_pkg::REG_ACR: read_data = r_acr;
                    via_pkg::REG_PCR: read_data = r_pcr;
                    via_pkg::REG_IFR: read_data = r_ifr;
                    default: read_data = {1'b1, r_ier};
                endcase
            end
            via_pkg::ACT_WRITE: begin
                unique case (i_item.reg_index) inside
                    via_pkg::REG_ORB: begin
                        n_out_b = i_item.write_data;
                        if (r_pcr[7:5] == via_pkg::C2_HANDSHAKE) begin
                            n_cb2_hand = 1'b0;
                        end
                    end
                    via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
                        if (i_item.reg_index == via_pkg::REG_ORA &&
                            r_pcr[3:1] == via_pkg::C2_HANDSHAKE) begin
                            n_ca2 = 1'b0;
                        end
                        n_out_a = i_item.write_data;
                    end
                    via_pkg::REG_DDRB: n_dir_b = i_item.write_data;
                    via_pkg::REG_DDRA: n_dir_a = i_item.write_data;
                    via_pkg::REG_T1CL, via_pkg::REG_T1LL: n_t1_latch_lo = i_item.write_data;
                    via_pkg::REG_T1CH: begin
                        n_t1_latch_hi = i_item.write_data;
                        n_t1_count = {i_item.write_data, r_t1_latch_lo};
                        flags[via_pkg::FLG_T1] = 1'b0;
                        n_t1_running = 1'b1;
                        n_t1_armed = 1'b1;
                        n_t1_pb7 = 1'b0;
                    end
                    via_pkg::REG_T1LH: n_t1_latch_hi = i_item.write_data;
                    via_pkg::REG_T2CL: n_t2_latch_lo = i_item.write_data;
                    via_pkg::REG_T2CH: begin
                        n_t2_count = {i_item.write_data, r_t2_latch_lo};
                        flags[via_pkg::FLG_T2] = 1'b0;
                        n_t2_running = 1'b1;
                        n_t2_armed = 1'b1;
                    end
                    via_pkg::REG_SR: begin
                        n_shift_reg = i_item.write_data;
                        flags[via_pkg::FLG_SR] = 1'b0;
                        n_shift_done = 4'd0;
                        n_shift_phase = 1'b1;
                    end
                    via_pkg::REG_ACR: n_acr = i_item.write_data;
                    via_pkg::REG_PCR: begin
                        n_pcr = i_item.write_data;
                        n_ca2 = (i_item.write_data[3:1] != via_pkg::C2_LOW);
                        n_cb2_hand = (i_item.write_data[7:5] != via_pkg::C2_LOW);
                    end
                    via_pkg::REG_IFR: flags = flags & ~i_item.write_data[6:0];
                    default: begin
                        if (i_item.write_data[7]) begin
                            n_ier = r_ier | i_item.write_data[6:0];
                        end else begin
                            n_ier = r_ier & ~i_item.write_data[6:0];
                        end
                    end
                endcase
            end
            default: ;
        endcase

        // irq bit is always the or of enabled flags
        n_ifr = {|(flags & n_ier), flags};

        o_result.read_data     = read_data;
        o_result.irq           = n_ifr[7];
        o_result.port_a_out    = n_out_a;
        o_result.port_b_out    = n_out_b;
        o_result.pb7_timer     = n_t1_pb7;
        o_result.ca2_level     = n_ca2;
        o_result.cb2_handshake = n_cb2_hand;
        o_result.cb2_shift     = n_cb2_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_a <= 8'h00;        r_out_b <= 8'h00;
            r_dir_a <= 8'h00;        r_dir_b <= 8'h00;
            r_t1_running <= 1'b0;    r_t1_armed <= 1'b0;
            r_t1_count <= 16'h0000;  r_t1_pb7 <= 1'b1;
            r_t1_latch_lo <= 8'h00;  r_t1_latch_hi <= 8'h00;
            r_t2_running <= 1'b0;    r_t2_armed <= 1'b0;
            r_t2_count <= 16'h0000;  r_t2_latch_lo <= 8'h00;
            r_shift_reg <= 8'h00;    r_shift_done <= via_pkg::SR_BITS_IDLE;
            r_shift_div <= 8'h00;    r_shift_phase <= 1'b0;
            r_acr <= 8'h00;          r_pcr <= 8'h00;
            r_ifr <= 8'h00;          r_ier <= 7'h00;
            r_ca2 <= 1'b1;           r_cb2_hand <= 1'b1;
            r_cb2_shift <= 1'b0;
        end else if (i_step) begin
            r_out_a <= n_out_a;              r_out_b <= n_out_b;
            r_dir_a <= n_dir_a;              r_dir_b <= n_dir_b;
            r_t1_running <= n_t1_running;    r_t1_armed <= n_t1_armed;
            r_t1_count <= n_t1_count;        r_t1_pb7 <= n_t1_pb7;
            r_t1_latch_lo <= n_t1_latch_lo;  r_t1_latch_hi <= n_t1_latch_hi;
            r_t2_running <= n_t2_running;    r_t2_armed <= n_t2_armed;
            r_t2_count <= n_t2_count;        r_t2_latch_lo <= n_t2_latch_lo;
            r_shift_reg <= n_shift_reg;      r_shift_done <= n_shift_done;
            r_shift_div <= n_shift_div;      r_shift_phase <= n_shift_phase;
            r_acr <= n_acr;                  r_pcr <= n_pcr;
            r_ifr <= n_ifr;                  r_ier <= n_ier;
            r_ca2 <= n_ca2;                  r_cb2_hand <= n_cb2_hand;
            r_cb2_shift <= n_cb2_shift;
        end
    end

    // irq summary bit tracks enabled flags
    a_irq_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ifr[7] == |(r_ifr[6:0] & r_ier))
        else $error("irq summary bit out of step with flags");

    // bit counter never passes idle
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_done <= via_pkg::SR_BITS_IDLE)
        else $error("shift bit count beyond eight");

    // a timer can only be armed while it runs
    a_t1_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t1_armed |-> r_t1_running)
        else $error("timer 1 armed while stopped");

    a_t2_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t2_armed |-> r_t2_running)
        else $error("timer 2 armed while stopped");

    // the timer counts hold while no word steps the core
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_t1_count) && $stable(r_t2_count))
        else $error("timer count moved without a word");

endmodule

// File: src/versatile_interface_adapter.sv
// top level of the interface adapter: stream ports, input and result registers
//
// 6522-style interface adapter driven by a stream of words. Each input word
// is one clock tick, one register read or one register write, chosen by
// tuser; every word returns exactly one result word holding the read byte
// (zero for ticks and writes) and the port, irq, pb7, ca2 and cb2 levels as
// they stand after the word. A word is held in the input register, is worked
// by the core in a single pass and lands in the result register, so one
// word is taken every cycle as long as the result side keeps taking words.
// The result register parts the two sides: a new word is taken while a
// finished result still waits. Reset is synchronous and active low; after
// reset t1 pb7, ca2 and cb2 handshake sit high and the shifter is idle.
module versatile_interface_adapter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_index[3:0], write_data[11:4], compare_in[12], port_a_external[20:13]
    input  logic [23:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], irq[8], port_a_out[16:9], port_b_out[24:17],
    // pb7_timer[25], ca2_level[26], cb2_handshake[27], cb2_shift[28]
    output logic [31:0] m_axis_tdata
);

    logic                  r_in_valid;
    via_pkg::t_via_item    r_in_item;
    logic                  r_out_valid;
    via_pkg::t_via_result  r_out;
    via_pkg::t_via_result  core_result;
    logic                  advance;

    // the held word moves on when the result slot is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.action          <= s_axis_tuser;
            r_in_item.reg_index       <= s_axis_tdata[3:0];
            r_in_item.write_data      <= s_axis_tdata[11:4];
            r_in_item.compare_in      <= s_axis_tdata[12];
            r_in_item.port_a_external <= s_axis_tdata[20:13];
        end
    end

    // state advances exactly once per word
    via_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule
